>>> src/stgs_pkg.sv
// Shared types and constants for the sorted table gap search block.
// No dependencies; imported by sorted_table_gap_search and by the bench modules.
package stgs_pkg;

  localparam int unsigned IdxW             = 10;
  localparam int unsigned FieldW           = 32;
  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned ValueWidthDefault = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [IdxW-1:0]          write_index;
    logic signed [FieldW-1:0] write_value;
    logic [IdxW-1:0]          search_low;
    logic [IdxW-1:0]          search_high;
    logic signed [FieldW-1:0] needle;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] position;
  } rsp_t;

endpackage

>>> src/stgs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module stgs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sorted_table_gap_search.sv
// Sorted table gap search: top level with the probe sequencer.
// Depends on stgs_pkg (types, constants) and stgs_ram (table storage).
//
// A request on req_i is taken at a rising edge with start high and busy low.
// A write request (command 0) stores write_value at write_index on that edge
// and never raises busy, so writes stream one per cycle while no search holds
// busy; indexes at or above TABLE_DEPTH are dropped. A search request
// (command 1) raises busy and probes the table through one registered-read
// RAM port, one probe per cycle: low end, high end, a halving-gap walk from
// the top, then a linear walk downward. The search ends at the low-end probe
// when that decides, else at the high-end probe, else when the walk ends;
// each probe waits on the registered read port. A search with low > high or
// high out of table answers not-found on the next cycle without going busy.
// The result sits on rsp_o for one cycle with done_o high and cannot be
// stalled; busy drops with the strobe, so the next request is taken then.
// cfg_data_i is the descending-order bit, written when cfg_valid_i and
// cfg_ready_o are high; the user must write it only while idle, the block
// does not enforce it. Reset clears the sequencer and the order bit; table
// contents are undefined until written.
module sorted_table_gap_search
  import stgs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request channel
  input  logic start,
  output logic busy,
  input  req_t req_i,
  // result channel
  output logic done_o,
  output rsp_t rsp_o,
  // configuration channel
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // waiting for a request
    S_LO    = 7'b0000010,  // RAM output holds table[low]
    S_HI    = 7'b0000100,  // RAM output holds table[high]
    S_START = 7'b0001000,  // first gap probe, outer loop test
    S_DOWN  = 7'b0010000,  // moving down while needle sorts before probe
    S_UP    = 7'b0100000,  // moving up while probe sorts before needle
    S_LIN   = 7'b1000000   // linear walk downward
  } state_e;

  // Signed value -> unsigned key of the same order (flip the sign bit).
  function automatic logic [VALUE_WIDTH-1:0] to_key(logic [FieldW-1:0] raw);
    logic [VALUE_WIDTH-1:0] k;
    k = VALUE_WIDTH'(raw);
    k[VALUE_WIDTH-1] = ~k[VALUE_WIDTH-1];
    return k;
  endfunction

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        lo_q, lo_d;
  logic [IdxW-1:0]        hi_q, hi_d;
  logic [IdxW-1:0]        h_q, h_d;
  logic [IdxW-1:0]        gap_q, gap_d;
  logic [VALUE_WIDTH-1:0] nk_q, nk_d;
  logic                   desc_q;
  logic                   done_q, done_d;
  logic                   found_q, found_d;
  logic [IdxW-1:0]        pos_q, pos_d;

  logic                   accept;
  logic                   wr_en;
  logic [IdxW-1:0]        rd_idx;
  logic [VALUE_WIDTH-1:0] probe;
  logic                   nb;   // needle sorts before probe
  logic                   pb;   // probe sorts before needle
  logic                   eq;
  logic [IdxW-1:0]        step;
  logic [IdxW-1:0]        dn_h;
  logic [IdxW-1:0]        up_h;
  logic                   range_ok;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Writes happen only at accept, never while a search is reading the table,
  // so no read/write forwarding is needed.
  assign wr_en = accept && (req_i.command == CMD_WRITE)
              && (32'(req_i.write_index) < 32'(TABLE_DEPTH));

  stgs_ram #(
    .Width (VALUE_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(req_i.write_index)),
    .wdata_i (to_key(req_i.write_value)),
    .raddr_i (AddrW'(rd_idx)),
    .rdata_o (probe)
  );

  assign nb = desc_q ? (nk_q > probe) : (nk_q < probe);
  assign pb = desc_q ? (probe > nk_q) : (probe < nk_q);
  assign eq = (probe == nk_q);

  // Gap moves, clamped to the ends of the range.
  assign step = gap_q >> 1;
  assign dn_h = (step > (h_q - lo_q)) ? lo_q : (h_q - step);
  assign up_h = (step > (hi_q - h_q)) ? hi_q : (h_q + step);

  assign range_ok = (req_i.search_low <= req_i.search_high)
                 && (32'(req_i.search_high) < 32'(TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    h_d     = h_q;
    gap_d   = gap_q;
    nk_d    = nk_q;
    done_d  = 1'b0;
    found_d = found_q;
    pos_d   = pos_q;
    rd_idx  = h_q;

    case (state_q)
      S_IDLE: begin
        rd_idx = req_i.search_low;
        if (accept && (req_i.command == CMD_SEARCH)) begin
          if (range_ok) begin
            lo_d    = req_i.search_low;
            hi_d    = req_i.search_high;
            nk_d    = to_key(req_i.needle);
            state_d = S_LO;
          end else begin
            done_d  = 1'b1;
            found_d = 1'b0;
            pos_d   = '0;
          end
        end
      end
      S_LO: begin
        rd_idx = hi_q;
        if (!pb) begin
          done_d  = 1'b1;
          found_d = eq;
          pos_d   = eq ? lo_q : '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_HI;
        end
      end
      S_HI: begin
        // Past the end test, low < high: the low end sorted before the needle.
        rd_idx = hi_q - 1'b1;
        if (pb || eq) begin
          done_d  = 1'b1;
          found_d = eq;
          pos_d   = eq ? hi_q : '0;
          state_d = S_IDLE;
        end else begin
          h_d     = hi_q - 1'b1;
          gap_d   = hi_q - 1'b1 - lo_q;
          state_d = ((hi_q - 1'b1 - lo_q) > IdxW'(2)) ? S_START : S_LIN;
        end
      end
      S_START: begin
        if (nb) begin
          h_d     = dn_h;
          gap_d   = step + 1'b1;
          rd_idx  = dn_h;
          state_d = S_DOWN;
        end else begin
          done_d  = 1'b1;
          found_d = eq;
          pos_d   = eq ? h_q : '0;
          state_d = S_IDLE;
        end
      end
      S_DOWN: begin
        if (nb) begin
          h_d    = dn_h;
          gap_d  = step + 1'b1;
          rd_idx = dn_h;
        end else if (pb) begin
          h_d     = up_h;
          gap_d   = step + 1'b1;
          rd_idx  = up_h;
          state_d = S_UP;
        end else begin
          // outer loop test fails on the same probe: the walk is over
          done_d  = 1'b1;
          found_d = eq;
          pos_d   = eq ? h_q : '0;
          state_d = S_IDLE;
        end
      end
      S_UP: begin
        if (pb) begin
          h_d    = up_h;
          gap_d  = step + 1'b1;
          rd_idx = up_h;
        end else if (gap_q < IdxW'(3)) begin
          // gap exhausted: linear tail with this probe
          if ((h_q > lo_q) && nb) begin
            h_d     = h_q - 1'b1;
            rd_idx  = h_q - 1'b1;
            state_d = S_LIN;
          end else begin
            done_d  = 1'b1;
            found_d = eq;
            pos_d   = eq ? h_q : '0;
            state_d = S_IDLE;
          end
        end else if (nb) begin
          h_d     = dn_h;
          gap_d   = step + 1'b1;
          rd_idx  = dn_h;
          state_d = S_DOWN;
        end else begin
          done_d  = 1'b1;
          found_d = eq;
          pos_d   = eq ? h_q : '0;
          state_d = S_IDLE;
        end
      end
      S_LIN: begin
        if ((h_q > lo_q) && nb) begin
          h_d    = h_q - 1'b1;
          rd_idx = h_q - 1'b1;
        end else begin
          done_d  = 1'b1;
          found_d = eq;
          pos_d   = eq ? h_q : '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      desc_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        desc_q <= cfg_data_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    h_q     <= h_d;
    gap_q   <= gap_d;
    nk_q    <= nk_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  assign done_o         = done_q;
  assign rsp_o.found    = found_q;
  assign rsp_o.position = pos_q;

endmodule

>>> bench/gap_search_checker.sv
// Checker for the sorted table gap search: watches every channel, predicts each search.
// Depends on stgs_pkg for the request and response types and the command codes.
module gap_search_checker
  import stgs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  rsp_t rsp_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic cfg_data_i,
  output int   mismatches_o,
  output int   awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_t query;
    rsp_t answer;
  } search_note_t;

  logic signed [FieldW-1:0] entries [TABLE_DEPTH];
  logic                     descending = 1'b0;
  search_note_t             awaited [$];
  int                       errors = 0;

  // Strict order in the configured direction.
  function automatic bit precedes(logic signed [FieldW-1:0] a, logic signed [FieldW-1:0] b);
    return descending ? (a > b) : (a < b);
  endfunction

  // Ends first, then the halving-gap walk from the top, then a linear walk down.
  function automatic rsp_t search_outcome(req_t q);
    int                       lo, hi, ceiling, h, gap, step;
    logic signed [FieldW-1:0] key;
    rsp_t                     res;
    res = '0;
    lo  = q.search_low;
    hi  = q.search_high;
    key = q.needle;
    if (lo > hi || hi >= TABLE_DEPTH) return res;
    if (!precedes(entries[lo], key)) begin
      if (entries[lo] == key) begin
        res.found    = 1'b1;
        res.position = IdxW'(lo);
      end
      return res;
    end
    if (precedes(entries[hi], key)) return res;
    if (entries[hi] == key) begin
      res.found    = 1'b1;
      res.position = IdxW'(hi);
      return res;
    end
    ceiling = hi;
    h       = hi - 1;
    gap     = h - lo;
    if (gap > 2) begin
      while (precedes(key, entries[h])) begin
        while (precedes(key, entries[h])) begin
          step = gap >> 1;
          h    = (step > h - lo) ? lo : h - step;
          gap  = step + 1;
        end
        while (precedes(entries[h], key)) begin
          step = gap >> 1;
          h    = (step > ceiling - h) ? ceiling : h + step;
          gap  = step + 1;
        end
        if (gap < 3) break;
      end
    end
    while (h > lo && precedes(key, entries[h])) h--;
    if (entries[h] == key) begin
      res.found    = 1'b1;
      res.position = IdxW'(h);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    search_note_t head;
    search_note_t fresh;
    if (!rst_ni) begin
      descending = 1'b0;
    end else begin
      if ($isunknown(done_i)) begin
        errors++;
        if (errors <= 10) $display("done strobe unknown at %0t", $realtime);
      end else if (done_i) begin
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result with no search outstanding: found %0b at %0d",
                     rsp_i.found, rsp_i.position);
        end else begin
          head = awaited.pop_front();
          if (rsp_i.found !== head.answer.found ||
              rsp_i.position !== head.answer.position) begin
            errors++;
            if (errors <= 10)
              $display("search %0d..%0d for %0d: expected found %0b at %0d, got found %0b at %0d",
                       head.query.search_low, head.query.search_high, head.query.needle,
                       head.answer.found, head.answer.position,
                       rsp_i.found, rsp_i.position);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (req_i.command == CMD_WRITE) begin
          if (req_i.write_index < TABLE_DEPTH) entries[req_i.write_index] = req_i.write_value;
        end else begin
          fresh.query  = req_i;
          fresh.answer = search_outcome(req_i);
          awaited.push_back(fresh);
        end
      end
      if (cfg_valid_i && cfg_ready_i) descending = cfg_data_i;
    end
    mismatches_o <= errors;
    awaiting_o   <= awaited.size();
  end

endmodule

>>> bench/sorted_table_gap_search_test.sv
// Top of the sorted table gap search bench: clock, reset, requests and the verdict.
// Depends on stgs_pkg, sorted_table_gap_search and gap_search_checker.
module sorted_table_gap_search_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stgs_pkg::*;

  localparam int Depth        = TableDepthDefault;
  // Low window of the table that is always written; wide random searches stay in it.
  localparam int Span         = 256;
  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 5;
  // Quiet time after a drain; a stray strobe would show well within it.
  localparam int SettleCycles = 48;
  localparam int StallLimit   = 4000;
  localparam int TotalItems   = 850;
  localparam logic signed [FieldW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [FieldW-1:0] MaxVal = 32'sh7fff_ffff;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic start     = 1'b0;
  req_t request   = '0;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;
  logic busy, done, cfg_ready;
  rsp_t outcome;
  int   fail_count, outstanding;

  // Stimulus-side copy of what was written, used to aim needles at real entries.
  logic signed [FieldW-1:0] mirror [Depth];
  logic descending   = 1'b0;
  bit   calm         = 1'b0;
  int   items_sent   = 0;
  int   stall_cycles = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  sorted_table_gap_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (request),
    .done_o      (done),
    .rsp_o       (outcome),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  gap_search_checker #(.TABLE_DEPTH(Depth)) check_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (request),
    .done_i       (done),
    .rsp_i        (outcome),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (fail_count),
    .awaiting_o   (outstanding)
  );

  // Watchdog: any accepted request, result strobe or config write counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Random idle between requests, about 12 in 100, none while calm is set.
  task automatic pause_or_go();
    if (!calm && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Hold start until the request is taken (start high, busy low at an edge).
  task automatic issue(input req_t r);
    request <= r;
    start   <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    pause_or_go();
  endtask

  // Unused fields carry random bits too, so every input bit toggles.
  function automatic req_t scrambled();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  task automatic write_entry(input int idx, input logic signed [FieldW-1:0] v);
    req_t r;
    r             = scrambled();
    r.command     = CMD_WRITE;
    r.write_index = IdxW'(idx);
    r.write_value = v;
    mirror[idx]   = v;
    issue(r);
  endtask

  task automatic look_up(input int lo, input int hi, input logic signed [FieldW-1:0] n);
    req_t r;
    r             = scrambled();
    r.command     = CMD_SEARCH;
    r.search_low  = IdxW'(lo);
    r.search_high = IdxW'(hi);
    r.needle      = n;
    issue(r);
  endtask

  // Write a run sorted in the current order; tight runs crowd values for duplicates.
  task automatic lay_run(input int lo, input int hi, input bit tight);
    int n;
    int base;
    int vals[];
    n    = hi - lo + 1;
    base = $urandom;
    vals = new[n];
    foreach (vals[k]) vals[k] = tight ? base + int'($urandom_range(0, 2 * n)) : int'($urandom);
    vals.sort();
    if (descending) vals.reverse();
    for (int k = 1; k < n; k++)
      if ($urandom_range(0, 7) == 0) vals[k] = vals[k-1];
    foreach (vals[k]) write_entry(lo + k, vals[k]);
  endtask

  // Mostly a value present in the range, else a near miss, an extreme, or noise.
  function automatic logic signed [FieldW-1:0] pick_needle(input int lo, input int hi);
    int k, roll;
    k    = $urandom_range(lo, hi);
    roll = $urandom_range(0, 9);
    if (roll < 6) return mirror[k];
    if (roll < 8) return $urandom_range(0, 1) ? mirror[k] + 1 : mirror[k] - 1;
    if (roll < 9) return $urandom_range(0, 1) ? MaxVal : MinVal;
    return $urandom;
  endfunction

  // Order bit changes only with the block idle: drain all results, then let it settle.
  task automatic set_order(input logic v);
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid  <= 1'b0;
    descending = v;
  endtask

  initial begin
    int lo, hi, a, b, size, roll, phase;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ascending window at the bottom of the table, extremes at both ends.
    set_order(1'b0);
    lay_run(0, Span - 1, 1'b0);
    write_entry(0, MinVal);
    write_entry(Span - 1, MaxVal);

    // Hits on each end and the middle, a miss between neighbors.
    look_up(0, Span - 1, MinVal);
    look_up(0, Span - 1, MaxVal);
    look_up(0, Span - 1, mirror[117]);
    look_up(0, Span - 1, mirror[30] + 1);
    // One-entry and two-entry ranges, and a range too short for the gap walk.
    look_up(7, 7, mirror[7]);
    look_up(7, 7, mirror[7] - 1);
    look_up(40, 41, mirror[41]);
    look_up(40, 43, mirror[42]);
    // Needle sorting before the low end, and after the high end.
    look_up(10, 200, mirror[5]);
    look_up(10, 200, mirror[250]);
    // Reversed range answers not-found at once.
    look_up(Span - 1, 0, MaxVal);
    // Run of duplicates: the reported index is where the walk lands.
    for (int k = 101; k <= 104; k++) write_entry(k, mirror[100]);
    look_up(90, 120, mirror[100]);
    // Broken order inside the range.
    write_entry(200, MaxVal);
    look_up(150, 250, mirror[220]);

    // Hits on both ends and the middle and a miss, on a short descending run.
    set_order(1'b1);
    lay_run(0, 63, 1'b0);
    write_entry(0, MaxVal);
    write_entry(63, MinVal);
    look_up(0, 63, MaxVal);
    look_up(0, 63, MinVal);
    look_up(0, 63, mirror[33]);
    look_up(0, 63, mirror[33] - 1);

    // Random phases: mostly flip the order, lay a fresh sorted region, search it hard.
    phase = 0;
    while (items_sent < TotalItems) begin
      set_order(($urandom_range(0, 3) == 0) ? descending : ~descending);
      calm = (phase == 2);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 160) : $urandom_range(1, 48);
      lo   = $urandom_range(0, Depth - size);
      hi   = lo + size - 1;
      lay_run(lo, hi, $urandom_range(0, 1));
      repeat ($urandom_range(20, 40)) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          if ($urandom_range(0, 2) == 0) begin
            a = lo;
            b = hi;
          end else begin
            a = $urandom_range(lo, hi);
            b = $urandom_range(a, hi);
          end
          look_up(a, b, pick_needle(a, b));
        end else if (roll < 78) begin
          write_entry($urandom_range(0, Depth - 1), $urandom);
        end else if (roll < 84) begin
          a = $urandom_range(1, Depth - 1);
          b = $urandom_range(0, a - 1);
          look_up(a, b, $urandom);
        end else begin
          a = $urandom_range(0, Span - 1);
          b = $urandom_range(a, Span - 1);
          look_up(a, b, pick_needle(a, b));
        end
      end
      phase++;
    end
    calm = 1'b0;

    // Drain, then give any stray strobe time to show up.
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
